@@ hdl/crcrv_pkg.sv @@
`default_nettype none

package crcrv_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned HdrLen = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcAllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] RecMagic = 32'h4C4E_5A53;

  typedef enum logic [2:0] {
    VerdictOk = 3'd0,
    VerdictBadMagic = 3'd1,
    VerdictBadVersion = 3'd2,
    VerdictBadSize = 3'd3,
    VerdictCrcMismatch = 3'd4
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgExpectedVersion = 2'd0,
    CfgExpectedSize = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic payload_valid;
    logic verdict_valid;
    verdict_e verdict;
  } result_t;

  // reflected CRC-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crcrv_if.sv @@
`default_nettype none

interface crcrv_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface crcrv_out_if;
  logic valid;
  logic ready;
  logic [7:0] payload_byte;
  logic payload_valid;
  logic verdict_valid;
  logic [2:0] verdict;
  modport source (output valid, output payload_byte, output payload_valid,
                  output verdict_valid, output verdict, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input verdict_valid, input verdict, output ready);
endinterface

interface crcrv_cfg_if;
  logic valid;
  logic ready;
  logic [crcrv_pkg::CfgIdxW-1:0] index;
  logic [crcrv_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/crc_checked_record_verifier.sv @@
// Each accepted item's result is registered and shown the cycle after.
// Throughput: one item per cycle when not stalled; the byte-wide CRC
// update and header compare sit between record state and result register.
// Reset (rst_ni low, asynchronous): record idle, position 0, CRC all ones,
// registers zero, result register empty.
`default_nettype none

module crc_checked_record_verifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  crcrv_in_if.sink         in_i,
  crcrv_out_if.source      out_o,
  crcrv_cfg_if.sink        cfg_i
);

  localparam logic [crcrv_pkg::PosW-1:0] HdrEnd = crcrv_pkg::PosW'(crcrv_pkg::HdrLen);

  logic [15:0] exp_version_q;
  logic [15:0] exp_size_q;

  logic [crcrv_pkg::PosW-1:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] trl_q, trl_d;
  crcrv_pkg::verdict_e fail_q, fail_d;
  logic active_q, active_d;

  crcrv_pkg::result_t res_d, out_q;
  logic out_valid_q;
  logic in_acc;

  logic [crcrv_pkg::PosW-1:0] pos_s, body_end, trl_off;
  logic [31:0] crc_s, trl_s, crc_next;
  crcrv_pkg::verdict_e fail_s, code;
  logic active_s;
  logic [7:0] want;
  logic [1:0] idx;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= '0;
      exp_size_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        crcrv_pkg::CfgExpectedVersion: exp_version_q <= cfg_i.data;
        crcrv_pkg::CfgExpectedSize: exp_size_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    active_s = in_i.first ? 1'b1 : active_q;
    pos_s = in_i.first ? '0 : pos_q;
    crc_s = in_i.first ? crcrv_pkg::CrcAllOnes : crc_q;
    trl_s = in_i.first ? 32'd0 : trl_q;
    fail_s = in_i.first ? crcrv_pkg::VerdictOk : fail_q;

    body_end = HdrEnd + crcrv_pkg::PosW'(exp_size_q);
    trl_off = pos_s - body_end;
    idx = (trl_off > crcrv_pkg::PosW'(3)) ? 2'd3 : trl_off[1:0];
    crc_next = crcrv_pkg::crc_byte(crc_s, in_i.data_byte);

    case (pos_s[2:0])
      3'd0, 3'd1, 3'd2, 3'd3: begin
        want = crcrv_pkg::RecMagic[{pos_s[1:0], 3'b000} +: 8];
        code = crcrv_pkg::VerdictBadMagic;
      end
      3'd4, 3'd5: begin
        want = exp_version_q[{pos_s[0], 3'b000} +: 8];
        code = crcrv_pkg::VerdictBadVersion;
      end
      default: begin
        want = exp_size_q[{pos_s[0], 3'b000} +: 8];
        code = crcrv_pkg::VerdictBadSize;
      end
    endcase

    active_d = active_s;
    pos_d = pos_s;
    crc_d = crc_s;
    trl_d = trl_s;
    fail_d = fail_s;
    res_d = '{payload_byte: 8'd0, payload_valid: 1'b0, verdict_valid: 1'b0,
              verdict: crcrv_pkg::VerdictOk};

    if (active_s) begin
      if (pos_s < HdrEnd) begin
        if (in_i.data_byte != want && fail_s == crcrv_pkg::VerdictOk) begin
          fail_d = code;
        end
        crc_d = crc_next;
        pos_d = pos_s + crcrv_pkg::PosW'(1);
      end else if (pos_s < body_end) begin
        crc_d = crc_next;
        pos_d = pos_s + crcrv_pkg::PosW'(1);
        res_d.payload_byte = in_i.data_byte;
        res_d.payload_valid = 1'b1;
      end else begin
        trl_d = trl_s | ({24'd0, in_i.data_byte} << {idx, 3'b000});
        if (idx == 2'd3) begin
          res_d.verdict_valid = 1'b1;
          res_d.verdict = fail_s;
          if (fail_s == crcrv_pkg::VerdictOk && ~crc_s != trl_d) begin
            res_d.verdict = crcrv_pkg::VerdictCrcMismatch;
          end
          active_d = 1'b0;
          pos_d = '0;
        end else begin
          pos_d = pos_s + crcrv_pkg::PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= crcrv_pkg::CrcAllOnes;
      trl_q <= '0;
      fail_q <= crcrv_pkg::VerdictOk;
      active_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      trl_q <= trl_d;
      fail_q <= fail_d;
      active_q <= active_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.verdict_valid = out_q.verdict_valid;
  assign out_o.verdict = out_q.verdict;

`ifndef SYNTHESIS
  a_pos_needs_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != '0 |-> active_q)
    else $error("position nonzero while idle");

  a_verdict_ends_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_d.verdict_valid |=> !active_q && pos_q == '0)
    else $error("record still active after verdict");

  a_one_kind_of_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.payload_valid && out_q.verdict_valid))
    else $error("payload and verdict in one result");

  a_verdict_zero_unless_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.verdict_valid |-> out_q.verdict == crcrv_pkg::VerdictOk)
    else $error("verdict code without verdict_valid");

  a_state_holds_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(pos_q) && $stable(crc_q) && $stable(active_q))
    else $error("record state moved without an accepted item");
`endif

endmodule

`default_nettype wire
